>>> sv/pressure_temperature_compensation_unit_assert.svh
// assertion helpers for the compensation unit
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define PTC_ASSERT_NOW(label, clock, reset_n, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define PTC_ASSERT_NXT(label, clock, reset_n, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> sv/ptc_pkg.sv
package ptc_pkg;

    // burst bytes of one reading
    typedef struct packed {
        logic [7:0] press_msb;
        logic [7:0] press_lsb;
        logic [7:0] press_xlsb;
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_xlsb;
    } sample_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [24:0]        pressure_fixed;
        logic               pressure_valid;
    } result_t;

    // unpacked 20-bit raw values
    typedef struct packed {
        logic [19:0] adc_p;
        logic [19:0] adc_t;
    } raw_t;

    typedef struct packed {
        logic [47:0] temp_words;
        logic [63:0] press_first;
        logic [63:0] press_second;
        logic [15:0] press_last;
    } trim_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_TEMP         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_PRESS_FIRST  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_PRESS_SECOND = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_PRESS_LAST   = 2'd3;

    localparam logic signed [14:0] TEMP_MIN_CENTI = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX_CENTI = 15'sd8500;

    // quotient bits produced by the divider pipeline
    localparam int unsigned DIV_QBITS = 38;

endpackage

>>> sv/ptc_front.sv
module ptc_front
    import ptc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  sample_t sample,
    output logic    fr_vld,
    output raw_t    fr_item,
    input  logic    fr_ready
);

    logic vld_reg;
    raw_t item_reg;
    logic take;

    assign full    = vld_reg && !fr_ready;
    assign take    = push && !full;
    assign fr_vld  = vld_reg;
    assign fr_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= 1'b1;
        end
        else if (fr_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    // low nibble of the xlsb bytes carries nothing
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.adc_p <= {sample.press_msb, sample.press_lsb, sample.press_xlsb[7:4]};
            item_reg.adc_t <= {sample.temp_msb, sample.temp_lsb, sample.temp_xlsb[7:4]};
        end
    end

endmodule

>>> sv/ptc_queue.sv
module ptc_queue
    import ptc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  raw_t wr_item,
    output logic full,
    input  logic rd,
    output raw_t rd_item,
    output logic empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    raw_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (do_rd)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> sv/ptc_back.sv
module ptc_back
    import ptc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  trim_t   trim,
    input  logic    q_empty,
    input  raw_t    q_item,
    output logic    q_rd,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam int unsigned DIV_FIRST = 12;
    localparam int unsigned POST      = DIV_FIRST + DIV_QBITS;
    localparam int unsigned NSTAGE    = POST + 5;

    localparam logic signed [63:0] DIVIDEND_LIMIT = 64'sd2951479051793528;
    localparam logic [38:0]        QUOT_MAG_NEG   = 39'd137438953472;
    localparam logic [38:0]        QUOT_MAG_POS   = 39'd137438961663;
    localparam logic signed [38:0] QUOT_LOW       = -39'sd137438953472;
    localparam logic signed [38:0] QUOT_HIGH      = 39'sd137438961663;
    localparam logic signed [40:0] PRESS_MAX      = 41'sd33554431;

    // everything one reading carries down the pipe; unused fields prune away
    typedef struct packed {
        logic [19:0]        adc_p;
        logic signed [17:0] a;
        logic signed [16:0] b;
        logic signed [33:0] m_a;
        logic signed [33:0] bsq;
        logic signed [22:0] ta;
        logic signed [36:0] m_b;
        logic signed [23:0] t_fine;
        logic signed [14:0] tc;
        logic signed [24:0] v1;
        logic signed [49:0] vsq;
        logic signed [40:0] v1p5;
        logic signed [40:0] v1p2;
        logic signed [63:0] vsq_p6;
        logic signed [63:0] vsq_p3;
        logic signed [63:0] v2;
        logic signed [55:0] sum;
        logic signed [55:0] hp;
        logic [32:0]        lp;
        logic signed [63:0] nraw;
        logic signed [39:0] dv;
        logic signed [63:0] nq;
        logic               pvalid;
        logic               qneg;
        logic               ovf;
        logic [62:0]        an;
        logic [39:0]        ad;
        logic [40:0]        rem;
        logic [37:0]        qmag;
        logic signed [38:0] pq;
        logic signed [25:0] q;
        logic [49:0]        qq;
        logic signed [54:0] p8p;
        logic signed [63:0] c1pre;
        logic signed [35:0] c2;
        logic signed [40:0] tot;
        logic [24:0]        pf;
    } bk_t;

    bk_t               pipe_reg  [NSTAGE];
    bk_t               pipe_next [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;
    logic              adv;

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = trim.temp_words[15:0];
    assign t2 = trim.temp_words[31:16];
    assign t3 = trim.temp_words[47:32];
    assign p1 = trim.press_first[15:0];
    assign p2 = trim.press_first[31:16];
    assign p3 = trim.press_first[47:32];
    assign p4 = trim.press_first[63:48];
    assign p5 = trim.press_second[15:0];
    assign p6 = trim.press_second[31:16];
    assign p7 = trim.press_second[47:32];
    assign p8 = trim.press_second[63:48];
    assign p9 = trim.press_last;

    // whole pipe holds only when the finished item is not taken
    assign adv   = !(vld_reg[NSTAGE-1] && !pop);
    assign q_rd  = adv && !q_empty;
    assign empty = !vld_reg[NSTAGE-1];

    assign result.temperature_centi = pipe_reg[NSTAGE-1].tc;
    assign result.pressure_fixed    = pipe_reg[NSTAGE-1].pf;
    assign result.pressure_valid    = pipe_reg[NSTAGE-1].pvalid;

    // temperature differences
    always_comb
    begin : s_diff
        bk_t x;
        x       = '0;
        x.adc_p = q_item.adc_p;
        x.a     = $signed({1'b0, q_item.adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
        x.b     = $signed({1'b0, q_item.adc_t[19:4]}) - $signed({1'b0, t1});
        pipe_next[0] = x;
    end

    always_comb
    begin : s_tmul
        bk_t x;
        x     = pipe_reg[0];
        x.m_a = x.a * t2;
        x.bsq = x.b * x.b;
        pipe_next[1] = x;
    end

    always_comb
    begin : s_tsq
        bk_t x;
        x     = pipe_reg[1];
        x.ta  = x.m_a[33:11];
        x.m_b = $signed(x.bsq[32:12]) * t3;
        pipe_next[2] = x;
    end

    always_comb
    begin : s_tfine
        bk_t               x;
        logic signed [22:0] tb;
        x        = pipe_reg[2];
        tb       = x.m_b[36:14];
        x.t_fine = 24'(x.ta) + 24'(tb);
        pipe_next[3] = x;
    end

    // centi-degrees and the pressure offset term
    always_comb
    begin : s_tout
        bk_t                x;
        logic signed [26:0] t5;
        logic signed [18:0] tcs;
        x   = pipe_reg[3];
        t5  = 27'(x.t_fine) * 27'sd5 + 27'sd128;
        tcs = t5[26:8];
        if (tcs < 19'(TEMP_MIN_CENTI))
        begin
            x.tc = TEMP_MIN_CENTI;
        end
        else if (tcs > 19'(TEMP_MAX_CENTI))
        begin
            x.tc = TEMP_MAX_CENTI;
        end
        else
        begin
            x.tc = tcs[14:0];
        end
        x.v1 = 25'(x.t_fine) - 25'sd128000;
        pipe_next[4] = x;
    end

    always_comb
    begin : s_vmul
        bk_t x;
        x      = pipe_reg[4];
        x.vsq  = x.v1 * x.v1;
        x.v1p5 = x.v1 * p5;
        x.v1p2 = x.v1 * p2;
        pipe_next[5] = x;
    end

    always_comb
    begin : s_vsq
        bk_t                x;
        logic signed [65:0] w6;
        logic signed [65:0] w3;
        x        = pipe_reg[5];
        w6       = x.vsq * p6;
        w3       = x.vsq * p3;
        x.vsq_p6 = w6[63:0];
        x.vsq_p3 = w3[63:0];
        pipe_next[6] = x;
    end

    always_comb
    begin : s_sums
        bk_t                x;
        logic signed [63:0] s64;
        x     = pipe_reg[6];
        x.v2  = x.vsq_p6 + (64'(x.v1p5) <<< 17) + (64'(p4) <<< 35);
        s64   = (x.vsq_p3 >>> 8) + (64'(x.v1p2) <<< 12) + 64'sd140737488355328;
        x.sum = s64[55:0];
        pipe_next[7] = x;
    end

    // divisor split in two partial products
    always_comb
    begin : s_dmul
        bk_t                x;
        logic signed [38:0] hi;
        logic [16:0]        lo;
        x      = pipe_reg[7];
        hi     = x.sum[55:17];
        lo     = x.sum[16:0];
        x.hp   = hi * $signed({1'b0, p1});
        x.lp   = lo * p1;
        x.nraw = ((64'sd1048576 - $signed({44'd0, x.adc_p})) <<< 31) - x.v2;
        pipe_next[8] = x;
    end

    always_comb
    begin : s_div_in
        bk_t                x;
        logic signed [55:0] d56;
        x    = pipe_reg[8];
        d56  = x.hp + $signed({40'd0, x.lp[32:17]});
        x.dv = d56[55:16];
        if (x.nraw > DIVIDEND_LIMIT)
        begin
            x.nq = DIVIDEND_LIMIT;
        end
        else if (x.nraw < -DIVIDEND_LIMIT)
        begin
            x.nq = -DIVIDEND_LIMIT;
        end
        else
        begin
            x.nq = x.nraw;
        end
        pipe_next[9] = x;
    end

    always_comb
    begin : s_scale
        bk_t x;
        x    = pipe_reg[9];
        x.nq = x.nq * 64'sd3125;
        pipe_next[10] = x;
    end

    // magnitudes, sign and quotient overflow check
    always_comb
    begin : s_mag
        bk_t x;
        x        = pipe_reg[10];
        x.an     = x.nq[63] ? 63'(-x.nq) : x.nq[62:0];
        x.ad     = x.dv[39] ? 40'(-x.dv) : 40'(x.dv);
        x.qneg   = x.nq[63] ^ x.dv[39];
        x.pvalid = (x.dv != '0);
        x.rem    = {16'd0, x.an[62:38]};
        x.ovf    = (x.rem >= {1'b0, x.ad});
        pipe_next[11] = x;
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < DIV_QBITS; j++)
    begin : g_div
        always_comb
        begin : s_div
            bk_t         x;
            logic [40:0] r;
            logic        ge;
            x  = pipe_reg[DIV_FIRST + j - 1];
            r  = {x.rem[39:0], x.an[DIV_QBITS - 1 - j]};
            ge = (r >= {1'b0, x.ad});
            x.rem = ge ? r - {1'b0, x.ad} : r;
            x.qmag[DIV_QBITS - 1 - j] = ge;
            pipe_next[DIV_FIRST + j] = x;
        end
    end

    always_comb
    begin : s_qsat
        bk_t         x;
        logic [38:0] qm;
        x  = pipe_reg[POST - 1];
        qm = {1'b0, x.qmag};
        if (x.qneg)
        begin
            x.pq = (x.ovf || qm > QUOT_MAG_NEG) ? QUOT_LOW : -$signed(qm);
        end
        else
        begin
            x.pq = (x.ovf || qm > QUOT_MAG_POS) ? QUOT_HIGH : $signed(qm);
        end
        pipe_next[POST] = x;
    end

    always_comb
    begin : s_qmul
        bk_t                x;
        logic signed [51:0] qsq;
        x     = pipe_reg[POST];
        x.q   = x.pq[38:13];
        qsq   = x.q * x.q;
        x.qq  = qsq[49:0];
        x.p8p = p8 * x.pq;
        pipe_next[POST + 1] = x;
    end

    always_comb
    begin : s_corr
        bk_t                x;
        logic signed [65:0] w;
        x       = pipe_reg[POST + 1];
        w       = p9 * $signed({1'b0, x.qq[48:0]});
        x.c1pre = w[63:0];
        x.c2    = x.p8p[54:19];
        pipe_next[POST + 2] = x;
    end

    always_comb
    begin : s_tot
        bk_t                x;
        logic signed [38:0] c1;
        x     = pipe_reg[POST + 2];
        c1    = x.c1pre[63:25];
        x.tot = 41'(x.pq) + 41'(c1) + 41'(x.c2);
        pipe_next[POST + 3] = x;
    end

    always_comb
    begin : s_pout
        bk_t                x;
        logic signed [32:0] th;
        logic signed [40:0] pr;
        x  = pipe_reg[POST + 3];
        th = x.tot[40:8];
        pr = 41'(th) + (41'(p7) <<< 4);
        if (!x.pvalid || pr < 41'sd0)
        begin
            x.pf = '0;
        end
        else if (pr > PRESS_MAX)
        begin
            x.pf = '1;
        end
        else
        begin
            x.pf = pr[24:0];
        end
        pipe_next[POST + 4] = x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], q_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
        end
    end

endmodule

>>> sv/pressure_temperature_compensation_unit.sv
// channel  | handshake        | payload             | notes
// ---------+------------------+---------------------+------------------------------
// sample   | push / full      | sample_t (6 bytes)  | one reading per item
// result   | pop / empty      | result_t            | oldest result shown while !empty
// cfg      | cfg_write        | cfg_index, cfg_data | trim words, no read-back
//
// takes one item per cycle while full stays low; a result passes the front register, queue and back pipe
// the back pipe has 12 setup stages, a 38-stage restoring divider
// (one quotient bit a stage) and 5 correction stages
// reset clears all valid state and zeroes the trim words
// a result left on the ports freezes the back pipe; front and queue still take items
// until the queue and front register fill, then full rises

`include "pressure_temperature_compensation_unit_assert.svh"

module pressure_temperature_compensation_unit
    import ptc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  sample_t                sample,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // trim words
    logic [47:0] trim_temp_reg;
    logic [63:0] trim_pfirst_reg;
    logic [63:0] trim_psecond_reg;
    logic [15:0] trim_plast_reg;
    trim_t       trim;

    // front to queue
    logic fr_vld;
    raw_t fr_item;
    logic q_full;

    // queue to back
    logic q_empty;
    logic q_rd;
    raw_t q_item;

    assign trim.temp_words   = trim_temp_reg;
    assign trim.press_first  = trim_pfirst_reg;
    assign trim.press_second = trim_psecond_reg;
    assign trim.press_last   = trim_plast_reg;

    // the user must write config only while idle (the block does not enforce it); the pipe reads these directly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_temp_reg    <= '0;
            trim_pfirst_reg  <= '0;
            trim_psecond_reg <= '0;
            trim_plast_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TRIM_TEMP:         trim_temp_reg    <= cfg_data[47:0];
                REG_TRIM_PRESS_FIRST:  trim_pfirst_reg  <= cfg_data;
                REG_TRIM_PRESS_SECOND: trim_psecond_reg <= cfg_data;
                REG_TRIM_PRESS_LAST:   trim_plast_reg   <= cfg_data[15:0];
                default:               trim_plast_reg   <= trim_plast_reg;
            endcase
        end
    end

    // front: takes the burst bytes and unpacks the raw values
    ptc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .fr_vld   (fr_vld),
        .fr_item  (fr_item),
        .fr_ready (!q_full)
    );

    // short queue decouples the front from back-pipe stalls
    ptc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fr_vld),
        .wr_item (fr_item),
        .full    (q_full),
        .rd      (q_rd),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    // back: compensation datapath, last stage is the result register
    ptc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .trim    (trim),
        .q_empty (q_empty),
        .q_item  (q_item),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // no pressure reported without a usable divisor
    `PTC_ASSERT_NOW(a_press_zero, clk, rst_n, !empty && !result.pressure_valid, result.pressure_fixed == '0, "pressure nonzero with valid cleared")

    // temperature always inside its saturation band
    `PTC_ASSERT_NOW(a_temp_band, clk, rst_n, !empty, (result.temperature_centi >= TEMP_MIN_CENTI) && (result.temperature_centi <= TEMP_MAX_CENTI), "temperature outside band")

    // full only when both front register and queue hold items
    `PTC_ASSERT_NOW(a_full_src, clk, rst_n, full, fr_vld && q_full, "full without backed-up queue")

    // an accepted item sits in the front register next cycle
    `PTC_ASSERT_NXT(a_take_held, clk, rst_n, push && !full, fr_vld, "accepted item lost in front")

endmodule

>>> test/pressure_temperature_compensation_unit_checker.sv
module pressure_temperature_compensation_unit_checker
    import ptc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  sample_t                sample,
    input  logic                   empty,
    input  logic                   pop,
    input  result_t                result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    trim_t   trim;
    result_t compensated_q[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic result_t compensate(sample_t s, trim_t tw);
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint adc_p, adc_t, a, ta, b, tb, t_fine, tc;
        longint v1, v2, w1, sum, hi, lo, divisor, n, p, q, c1, c2;
        result_t r;
        t1 = longint'({16'd0, tw.temp_words[15:0]});
        t2 = longint'($signed(tw.temp_words[31:16]));
        t3 = longint'($signed(tw.temp_words[47:32]));
        p1 = longint'({16'd0, tw.press_first[15:0]});
        p2 = longint'($signed(tw.press_first[31:16]));
        p3 = longint'($signed(tw.press_first[47:32]));
        p4 = longint'($signed(tw.press_first[63:48]));
        p5 = longint'($signed(tw.press_second[15:0]));
        p6 = longint'($signed(tw.press_second[31:16]));
        p7 = longint'($signed(tw.press_second[47:32]));
        p8 = longint'($signed(tw.press_second[63:48]));
        p9 = longint'($signed(tw.press_last));
        adc_p = longint'({44'd0, s.press_msb, s.press_lsb, s.press_xlsb[7:4]});
        adc_t = longint'({44'd0, s.temp_msb, s.temp_lsb, s.temp_xlsb[7:4]});
        // temperature path
        a = (adc_t >>> 3) - 2 * t1;
        ta = (a * t2) >>> 11;
        b = (adc_t >>> 4) - t1;
        tb = (((b * b) >>> 12) * t3) >>> 14;
        t_fine = ta + tb;
        tc = clamp((t_fine * 5 + 128) >>> 8, -4000, 8500);
        // pressure path
        v1 = t_fine - 128000;
        v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * 64'sd34359738368;
        w1 = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
        sum = 64'sd140737488355328 + w1;
        hi = sum >>> 17;
        lo = sum - hi * 131072;
        divisor = (hi * p1 + ((lo * p1) >>> 17)) >>> 16;
        r.temperature_centi = tc[14:0];
        r.pressure_fixed = '0;
        r.pressure_valid = 1'b0;
        // zero divisor leaves pressure at zero and not valid
        if (divisor != 0)
        begin
            n = (1048576 - adc_p) * 64'sd2147483648 - v2;
            n = clamp(n, -(64'sh7fffffffffffffff / 3125), 64'sh7fffffffffffffff / 3125);
            p = (n * 3125) / divisor;
            p = clamp(p, -64'sd137438953472, 64'sd137438953472 + 8191);
            q = p >>> 13;
            c1 = (p9 * (q * q)) >>> 25;
            c2 = (p8 * p) >>> 19;
            p = ((p + c1 + c2) >>> 8) + p7 * 16;
            p = clamp(p, 0, 33554431);
            r.pressure_fixed = p[24:0];
            r.pressure_valid = 1'b1;
        end
        return r;
    endfunction

    assign pending = compensated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim <= '0;
            fail_count <= 0;
            compensated_q.delete();
        end
        else
        begin
            result_t exp_r;
            if (push && !full)
                compensated_q.push_back(compensate(sample, trim));
            if (pop && !empty)
            begin
                if (compensated_q.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = compensated_q.pop_front();
                    if (result !== exp_r)
                    begin
                        fail_count <= fail_count + 1;
                        if (result.temperature_centi !== exp_r.temperature_centi)
                            $error("temperature_centi expected %0d actual %0d",
                                   exp_r.temperature_centi, result.temperature_centi);
                        if (result.pressure_fixed !== exp_r.pressure_fixed)
                            $error("pressure_fixed expected %0d actual %0d",
                                   exp_r.pressure_fixed, result.pressure_fixed);
                        if (result.pressure_valid !== exp_r.pressure_valid)
                            $error("pressure_valid expected %0d actual %0d",
                                   exp_r.pressure_valid, result.pressure_valid);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TRIM_TEMP:         trim.temp_words   <= cfg_data[47:0];
                    REG_TRIM_PRESS_FIRST:  trim.press_first  <= cfg_data;
                    REG_TRIM_PRESS_SECOND: trim.press_second <= cfg_data;
                    REG_TRIM_PRESS_LAST:   trim.press_last   <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> test/pressure_temperature_compensation_unit_tb.sv
module pressure_temperature_compensation_unit_tb
    import ptc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    sample_t                sample;
    logic                   empty;
    logic                   pop;
    result_t                result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;
    int                     cycles;
    // idle and stall odds in percent, switched per phase
    int                     send_idle_pct;
    int                     pop_stall_pct;

    pressure_temperature_compensation_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pressure_temperature_compensation_unit_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on the whole run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side stalls at random, changed at the falling edge
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop = ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // one item, held until the block takes it
    task automatic send_reading(sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        sample = s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        push = 1'b0;
    endtask

    // trim writes only once the pipe has drained
    task automatic write_trim(logic [63:0] t_words, logic [63:0] p_first,
                              logic [63:0] p_second, logic [63:0] p_last);
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = REG_TRIM_TEMP;
        cfg_data = t_words;
        @(negedge clk);
        cfg_index = REG_TRIM_PRESS_FIRST;
        cfg_data = p_first;
        @(negedge clk);
        cfg_index = REG_TRIM_PRESS_SECOND;
        cfg_data = p_second;
        @(negedge clk);
        cfg_index = REG_TRIM_PRESS_LAST;
        cfg_data = p_last;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic sample_t random_reading();
        sample_t s;
        s = {$urandom, 16'($urandom)};
        // mostly readings near a real operating point, the rest full range
        if ($urandom_range(99) < 60)
        begin
            s.press_msb = 8'h50 + 8'($urandom_range(63));
            s.temp_msb = 8'h78 + 8'($urandom_range(31));
        end
        return s;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [63:0] t_words;
        logic [63:0] p_first;
        logic [63:0] p_second;
        push = 1'b0;
        sample = '0;
        cfg_write = 1'b0;
        cfg_index = REG_TRIM_TEMP;
        cfg_data = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // zero trims after reset: divisor is zero, pressure not valid
        send_reading('0);
        send_reading('1);
        send_reading(48'h8000_0080_0000);
        send_reading(48'h0F0F_0F0F_0F0F);

        // typical trims, then byte extremes and the ignored low nibble
        write_trim({16'hFC18, 16'd26435, 16'd27504},
                   {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                   64'd6000);
        send_reading('0);
        send_reading('1);
        send_reading(48'h6553_0F7E_E000);
        send_reading(48'h6553_0F7E_E00F);
        send_reading(48'hFFFF_F000_0000);
        send_reading(48'h0000_00FF_FFFF);
        send_reading(48'h8000_0000_0000);
        send_reading(48'hAA55_A055_AA50);
        send_reading(48'h55AA_50AA_55A0);
        send_reading(48'h0000_0000_00F0);

        // extreme trims: huge dividend and quotient saturation, temperature clamps
        write_trim({16'h7FFF, 16'h7FFF, 16'd0}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1},
                   {16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF);
        send_reading('0);
        send_reading('1);
        send_reading(48'h8000_0080_0000);
        write_trim({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                   {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
        send_reading('0);
        send_reading('1);
        send_reading(48'h0000_00FF_FFFF);

        // random part: each phase a new trim setting and a new idling mode
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 68; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 68; end
                default: begin send_idle_pct = 14; pop_stall_pct = 14; end
            endcase
            if (phase % 3 == 0)
            begin
                // random walk around the typical setting
                t_words = {16'hFC18 + 16'($urandom_range(255)), 16'd26435 + 16'($urandom_range(511)),
                           16'd27504 + 16'($urandom_range(1023))};
                p_first = {16'($urandom_range(4095)), 16'($urandom_range(4095)),
                           16'hD643 + 16'($urandom_range(255)), 16'd36477 + 16'($urandom_range(511))};
                p_second = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140} ^ 64'($urandom_range(255));
                write_trim(t_words, p_first, p_second, 64'($urandom_range(8191)));
            end
            else
                write_trim(rand64(), rand64(), rand64(), rand64());
            for (int k = 0; k < 63; k++)
                send_reading(random_reading());
        end

        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
